// ===== rtl/core/wbm_pkg.sv =====
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types and constants for the waveform bucket min/max unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wbm_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned INDEX_BITS   = 20;
  localparam int unsigned CHAN_BITS    = 3;
  localparam int unsigned FRAME_BITS   = 16;
  localparam int unsigned CCOUNT_BITS  = 4;

  localparam logic [FRAME_BITS-1:0]  BUCKET_FRAMES_RST = FRAME_BITS'(256);
  localparam logic [CCOUNT_BITS-1:0] CHANNEL_COUNT_RST = CCOUNT_BITS'(2);
  localparam logic [FRAME_BITS-1:0]  FRAME_SAT         = '1;

  typedef enum logic {
    REG_BUCKET_FRAMES = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic                  load;
    logic [CHAN_BITS-1:0]  last_ch;
    logic [INDEX_BITS-1:0] index;
  } wbm_load_t;

endpackage

`default_nettype wire

// ===== rtl/core/waveform_bucket_minmax_unit.sv =====
// ----------------------------------------------------------------------------
// waveform_bucket_minmax_unit
// Min/max decimation of a multichannel sample stream into buckets.
// ----------------------------------------------------------------------------
// Input channel: one frame per beat, eight signed samples plus end_of_stream.
// Eight lanes fold every frame into their running min/max in the accepting
// cycle, so frames are taken one per clock unless held off by in_stall_o.
// Output channel: when a frame fills the bucket, or carries end_of_stream,
// the lanes are captured and one beat per active channel (at least one)
// follows, in channel order, starting the cycle after that frame;
// last_of_bucket marks the final beat.
// A frame that closes a bucket is held off (in_stall_o) while the previous
// bucket has beats pending and its final beat is not taken in the same cycle;
// others are never held. A receiver stall holds the current beat unchanged.
// Configuration: cfg index 0 bucket_frames, index 1 channel_count, written
// while idle.
// Reset: bucket_frames 256, channel_count 2, frame and bucket counts zero,
// no beats pending.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_bucket_minmax_unit
  import wbm_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_index_i,
  input  wire  [FRAME_BITS-1:0]  cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  sample_t                sample_0_i,
  input  sample_t                sample_1_i,
  input  sample_t                sample_2_i,
  input  sample_t                sample_3_i,
  input  sample_t                sample_4_i,
  input  sample_t                sample_5_i,
  input  sample_t                sample_6_i,
  input  sample_t                sample_7_i,
  input  wire                    end_of_stream_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [CHAN_BITS-1:0]   channel_o,
  output logic [INDEX_BITS-1:0]  bucket_index_o,
  output sample_t                low_value_o,
  output sample_t                high_value_o,
  output logic                   last_of_bucket_o
);

  logic [FRAME_BITS-1:0]  bucket_frames_q;
  logic [CCOUNT_BITS-1:0] channel_count_q;
  logic [FRAME_BITS-1:0]  frames_q, frames_d, frames_inc, size;
  logic [INDEX_BITS-1:0]  bucket_q, bucket_d;
  logic [CHAN_BITS-1:0]   last_ch;
  logic                   close, accept, free;
  wbm_load_t              load;
  sample_t                samples   [MAX_CHANNELS];
  sample_t                lane_low  [MAX_CHANNELS];
  sample_t                lane_high [MAX_CHANNELS];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;
  assign samples[6] = sample_6_i;
  assign samples[7] = sample_7_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_frames_q <= BUCKET_FRAMES_RST;
      channel_count_q <= CHANNEL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_BUCKET_FRAMES: bucket_frames_q <= cfg_data_i;
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CCOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign frames_inc = (frames_q == FRAME_SAT) ? FRAME_SAT : frames_q + FRAME_BITS'(1);
  assign size       = (bucket_frames_q == '0) ? FRAME_BITS'(1) : bucket_frames_q;
  assign close      = end_of_stream_i || (frames_inc >= size);
  assign in_stall_o = close && !free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (channel_count_q == '0) begin
      last_ch = '0;
    end else if (channel_count_q > CCOUNT_BITS'(MAX_CHANNELS)) begin
      last_ch = CHAN_BITS'(MAX_CHANNELS - 1);
    end else begin
      last_ch = CHAN_BITS'(channel_count_q - CCOUNT_BITS'(1));
    end
  end

  always_comb begin
    frames_d = frames_q;
    bucket_d = bucket_q;
    if (accept) begin
      if (close) begin
        frames_d = '0;
        bucket_d = bucket_q + INDEX_BITS'(1);
      end else begin
        frames_d = frames_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
      bucket_q <= '0;
    end else begin
      frames_q <= frames_d;
      bucket_q <= bucket_d;
    end
  end

  assign load.load    = accept && close;
  assign load.last_ch = last_ch;
  assign load.index   = bucket_q;

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    wbm_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .fold_i      (accept),
      .first_i     (frames_q == '0),
      .sample_i    (samples[c]),
      .low_next_o  (lane_low[c]),
      .high_next_o (lane_high[c])
    );
  end

  wbm_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .lane_low_i       (lane_low),
    .lane_high_i      (lane_high),
    .free_o           (free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_o        (channel_o),
    .bucket_index_o   (bucket_index_o),
    .low_value_o      (low_value_o),
    .high_value_o     (high_value_o),
    .last_of_bucket_o (last_of_bucket_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/wbm_lane.sv =====
// ----------------------------------------------------------------------------
// wbm_lane
// Running minimum and maximum of one channel over the current bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_lane
  import wbm_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     fold_i,
  input  wire     first_i,
  input  sample_t sample_i,
  output sample_t low_next_o,
  output sample_t high_next_o
);

  sample_t low_q, high_q;
  sample_t low_d, high_d;

  always_comb begin
    if (first_i) begin
      low_d  = sample_i;
      high_d = sample_i;
    end else begin
      low_d  = (sample_i < low_q)  ? sample_i : low_q;
      high_d = (sample_i > high_q) ? sample_i : high_q;
    end
  end

  assign low_next_o  = low_d;
  assign high_next_o = high_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
    end else if (fold_i) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wbm_merge.sv =====
// ----------------------------------------------------------------------------
// wbm_merge
// Capture the lane results of a closed bucket and send them one beat per
// channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_merge
  import wbm_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wbm_load_t              load_i,
  input  sample_t                lane_low_i  [MAX_CHANNELS],
  input  sample_t                lane_high_i [MAX_CHANNELS],
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [CHAN_BITS-1:0]   channel_o,
  output logic [INDEX_BITS-1:0]  bucket_index_o,
  output sample_t                low_value_o,
  output sample_t                high_value_o,
  output logic                   last_of_bucket_o
);

  sample_t               snap_low_q  [MAX_CHANNELS];
  sample_t               snap_high_q [MAX_CHANNELS];
  logic [INDEX_BITS-1:0] index_q;
  logic [CHAN_BITS-1:0]  last_q;
  logic [CHAN_BITS-1:0]  pos_q, pos_d;
  logic                  busy_q, busy_d;
  logic                  beat, last_beat;

  assign beat      = busy_q && !out_stall_i;
  assign last_beat = beat && (pos_q == last_q);
  assign free_o    = !busy_q || last_beat;

  always_comb begin
    pos_d  = pos_q;
    busy_d = busy_q;
    if (beat) begin
      pos_d = pos_q + CHAN_BITS'(1);
      if (last_beat) busy_d = 1'b0;
    end
    if (load_i.load) begin
      pos_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        snap_low_q[c]  <= lane_low_i[c];
        snap_high_q[c] <= lane_high_i[c];
      end
      index_q <= load_i.index;
      last_q  <= load_i.last_ch;
    end
  end

  assign out_valid_o      = busy_q;
  assign channel_o        = pos_q;
  assign bucket_index_o   = index_q;
  assign low_value_o      = snap_low_q[pos_q];
  assign high_value_o     = snap_high_q[pos_q];
  assign last_of_bucket_o = (pos_q == last_q);

endmodule

`default_nettype wire
